// ===== sv/b64e_pkg.sv =====
package b64e_pkg;

    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = 1;
    localparam int unsigned QCntW  = 2;

    localparam logic [7:0] PadChar = 8'h3d;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        priority if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2b;
        end else begin
            c = 8'h2f;
        end
        return c;
    endfunction

endpackage

// ===== sv/b64e_front.sv =====
module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    input  t_q_status  i_q_status,
    output logic       o_stall,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [1:0] r_pos, n_pos;
    logic [3:0] r_left, n_left;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        n_pos         = r_pos;
        n_left        = r_left;
        o_entry.chars = {PadChar, PadChar, PadChar, PadChar};
        o_entry.fin   = i_final_byte;
        if (r_pos == 2'd2) begin
            o_entry.chars[0] = sextet_char({r_left, i_data_byte[7:6]});
            o_entry.chars[1] = sextet_char(i_data_byte[5:0]);
            o_entry.last_idx = 2'd1;
            n_pos            = 2'd0;
            n_left           = 4'd0;
        end else if (r_pos == 2'd1) begin
            o_entry.chars[0] = sextet_char({r_left[1:0], i_data_byte[7:4]});
            o_entry.chars[1] = sextet_char({i_data_byte[3:0], 2'b00});
            o_entry.last_idx = i_final_byte ? 2'd2 : 2'd0;
            n_pos            = 2'd2;
            n_left           = i_data_byte[3:0];
        end else begin
            // position 3 never arises; decode it as the start of a group
            o_entry.chars[0] = sextet_char(i_data_byte[7:2]);
            o_entry.chars[1] = sextet_char({i_data_byte[1:0], 4'b0000});
            o_entry.last_idx = i_final_byte ? 2'd3 : 2'd0;
            n_pos            = 2'd1;
            n_left           = {2'b00, i_data_byte[1:0]};
        end
        if (i_final_byte) begin
            n_pos  = 2'd0;
            n_left = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_left <= 4'd0;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

endmodule

// ===== sv/b64e_fifo.sv =====
module b64e_fifo
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    t_entry             r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QCntW-1:0]   r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCntW'(QDepth));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/b64e_back.sv =====
module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic       o_message_end
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_run_last;
    logic       r_msg_end;
    logic       w_load;
    logic       w_last;

    assign w_load = (!r_valid || !i_stall) && !i_q_status.empty;
    assign w_last = (r_idx == i_head.last_idx);
    assign o_pop  = w_load && w_last;

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_run_last    = r_run_last;
    assign o_message_end = r_msg_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold payload while the output is stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char     <= i_head.chars[r_idx];
            r_run_last <= w_last;
            r_msg_end  <= w_last && i_head.fin;
        end
    end

endmodule

// ===== sv/base64_stream_encoder.sv =====
// Channel  Dir  Handshake          Payload
// input    in   i_valid / o_stall  i_data_byte[7:0], i_final_byte
// output   out  o_valid / i_stall  o_out_char[7:0], o_run_last, o_message_end
//
// One character leaves per cycle unless the output stalls or the queue is empty.
// A byte yields 1 to 4 characters, an ordinary byte 4/3 on average and at most 2.
// The rate is set by the single-character output register in the back end.
// A two-entry queue between classifier and serializer lets input keep flowing
// while the output stalls. Reset is synchronous, active low, and empties the
// queue and the output register; the group position returns to the start.
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic       o_message_end
);

    t_q_status w_q_status;
    t_entry    w_entry;
    t_entry    w_head;
    logic      w_push;
    logic      w_pop;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_q_status   (w_q_status),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_entry      (w_entry)
    );

    b64e_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_end |-> o_run_last)
        else $error("message end without run last");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("queue pushed while full");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && w_q_status.empty)
        else $error("reset left output or queue occupied");

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import b64e_pkg::*;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned RandItems  = 96;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_enc_char;

    // Mirrors the encoder: group position, leftover bits, and the characters owed.
    class char_scoreboard;
        t_enc_char  owed_q[$];
        logic [1:0] grp_pos;
        logic [3:0] carry;
        int         errors;
        string      alphabet;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            grp_pos  = 2'd0;
            carry    = 4'd0;
            errors   = 0;
        endfunction

        function logic [7:0] b64_char(logic [5:0] v);
            return alphabet[int'(v)];
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_byte(logic [7:0] d, logic fin);
            logic [7:0] c [4];
            int         n;
            t_enc_char  e;
            n = 0;
            if (grp_pos == 2'd1) begin
                c[0]    = b64_char({carry[1:0], d[7:4]});
                n       = 1;
                carry   = d[3:0];
                grp_pos = 2'd2;
                if (fin) begin
                    c[1] = b64_char({d[3:0], 2'b00});
                    c[2] = PadChar;
                    n    = 3;
                end
            end else if (grp_pos == 2'd2) begin
                c[0]    = b64_char({carry, d[7:6]});
                c[1]    = b64_char(d[5:0]);
                n       = 2;
                carry   = 4'd0;
                grp_pos = 2'd0;
            end else begin
                // position 0, and the unused position 3 decoded the same way
                c[0]    = b64_char(d[7:2]);
                n       = 1;
                carry   = {2'b00, d[1:0]};
                grp_pos = 2'd1;
                if (fin) begin
                    c[1] = b64_char({d[1:0], 4'b0000});
                    c[2] = PadChar;
                    c[3] = PadChar;
                    n    = 4;
                end
            end
            if (fin) begin
                grp_pos = 2'd0;
                carry   = 4'd0;
            end
            for (int k = 0; k < n; k++) begin
                e.ch       = c[k];
                e.run_last = (k == n - 1);
                e.msg_end  = (k == n - 1) && fin;
                owed_q.push_back(e);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic rl, logic me);
            t_enc_char e;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected char 0x%02h run_last %0b message_end %0b",
                         $time, ch, rl, me);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (ch !== e.ch) begin
                $display("%0t: out_char expected 0x%02h actual 0x%02h", $time, e.ch, ch);
                errors++;
            end
            if (rl !== e.run_last) begin
                $display("%0t: run_last expected %0b actual %0b", $time, e.run_last, rl);
                errors++;
            end
            if (me !== e.msg_end) begin
                $display("%0t: message_end expected %0b actual %0b", $time, e.msg_end, me);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       i_final_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_char;
    logic       o_run_last;
    logic       o_message_end;

    char_scoreboard sb;

    int unsigned cycles;
    logic        tx_idle_en;
    logic        rx_idle_en;
    logic        hold_req;
    int unsigned hold_left;
    int unsigned rx_left;
    logic        rx_level;
    int unsigned rx_pick;

    logic [7:0] dir_data [24] = '{
        8'h00,
        8'hff,
        8'hff, 8'hff,
        8'h00, 8'h00,
        8'hff, 8'hff, 8'hff,
        8'h4d, 8'h61, 8'h6e,
        8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55,
        8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'h01
    };
    logic dir_fin [24] = '{
        1'b1,
        1'b1,
        1'b0, 1'b1,
        1'b0, 1'b1,
        1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };

    base64_stream_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: check each transfer, then pick the next stall level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_char(o_out_char, o_run_last, o_message_end);
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (!rx_idle_en) begin
            i_stall <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 50) begin
                    rx_level = 1'b0;
                    rx_left  = $urandom_range(1, 8);
                end else if (rx_pick < 90) begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(1, 3);
                end else begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(10, 40);
                end
            end
            rx_left = rx_left - 1;
            i_stall <= rx_level;
        end
    end

    // Call aligned to a rising edge; returns aligned to a rising edge.
    task automatic send_byte(input logic [7:0] d, input logic fin);
        int unsigned r;
        int unsigned gap;
        i_valid      <= 1'b1;
        i_data_byte  <= d;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(d, fin);
        gap = 0;
        if (tx_idle_en) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                gap = 0;
            end else if (r < 90) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(8, 30);
            end
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_messages(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        logic        fin;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(10, 20);
            end else begin
                len = $urandom_range(1, 9);
            end
            for (int unsigned k = 0; k < len; k++) begin
                // mostly terminate on the last byte, now and then cut short
                fin = (k == len - 1) || ($urandom_range(0, 19) == 0);
                send_byte(8'($urandom_range(0, 255)), fin);
                sent++;
                if (fin) break;
            end
        end
    endtask

    initial begin
        sb           = new();
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data_byte  = 8'h00;
        i_final_byte = 1'b0;
        i_stall      = 1'b0;
        cycles       = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_req     = 1'b0;
        hold_left    = 0;
        rx_left      = 0;
        rx_level     = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 24; k++) begin
            send_byte(dir_data[k], dir_fin[k]);
        end

        send_random_messages(RandItems * 2 / 5);

        // back to back on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_messages(RandItems / 5);

        // long output hold-off while input keeps coming, to fill the queue
        hold_req = 1'b1;
        send_random_messages(RandItems / 5);

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_messages(RandItems / 5);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
